### hdl/nmt_pkg.sv
// Shared types, constants and helpers for the modular transform block.
// No dependencies; nmt_modmul, the top level and the checker import this package.
`timescale 1ns / 1ps
`default_nettype none
package nmt_pkg;
	localparam int MAX_LOG2_LENGTH = 12;
	localparam int IDX_W = MAX_LOG2_LENGTH;
	localparam int DEPTH = 1 << MAX_LOG2_LENGTH;
	localparam int WORD_W = 64;
	localparam int LOG_W = 4;
	localparam int CNT_W = 6;
	localparam int IN_DATA_W = 80;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [1:0] {
		MODE_TWIDDLE = 2'd0,
		MODE_COEFF   = 2'd1,
		MODE_RUN     = 2'd2,
		MODE_READ    = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODULUS    = 2'd0,
		REG_LOG2_LEN   = 2'd1,
		REG_INVERSE    = 2'd2,
		REG_LENGTH_INV = 2'd3
	} reg_idx_t;

	// request to the modular arithmetic unit
	typedef struct packed {
		logic start;
		logic op_mul;
	} mul_req_t;

	function automatic logic [IDX_W-1:0] mirror_index(input logic [IDX_W-1:0] x);
		logic [IDX_W-1:0] r;
		for (int b = 0; b < IDX_W; b++) begin
			r[b] = x[IDX_W-1-b];
		end
		return r;
	endfunction
endpackage
`default_nettype wire

### hdl/nmt_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module nmt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### hdl/nmt_modmul.sv
// Bit-serial modular unit: reduces an operand mod q, or multiplies two
// operands mod q by double-and-add, one bit per cycle. Uses nmt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nmt_modmul (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire nmt_pkg::mul_req_t        req,
	input  wire logic [nmt_pkg::WORD_W-1:0] a,
	input  wire logic [nmt_pkg::WORD_W-1:0] b,
	input  wire logic [nmt_pkg::WORD_W-1:0] q,
	output logic                          done,
	output logic      [nmt_pkg::WORD_W-1:0] result
);
	import nmt_pkg::*;

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_LOAD = 5'b00010,
		PH_RED  = 5'b00100,
		PH_MUL  = 5'b01000,
		PH_DONE = 5'b10000
	} phase_t;

	phase_t phase_q;
	logic op_mul_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WORD_W-1:0] r_q, a_q, b_q, result_q;

	logic q_zero;
	logic [WORD_W:0] q_ext, red_t, red_v, dbl_t, dbl_v, add_t, add_v;

	always_comb begin
		q_zero = (q == '0);
		q_ext = {1'b0, q};
		// reduction step: r = 2r + next bit of a, mod q
		red_t = {r_q, a_q[cnt_q]};
		red_v = (!q_zero && red_t >= q_ext) ? red_t - q_ext : red_t;
		// multiply step: r = 2r (+ a when the bit of b is set), mod q
		dbl_t = {r_q, 1'b0};
		dbl_v = (!q_zero && dbl_t >= q_ext) ? dbl_t - q_ext : dbl_t;
		add_t = {1'b0, dbl_v[WORD_W-1:0]} + {1'b0, (b_q[cnt_q] ? a_q : '0)};
		add_v = (!q_zero && add_t >= q_ext) ? add_t - q_ext : add_t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			op_mul_q <= 1'b0;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					if (req.start) begin
						op_mul_q <= req.op_mul;
						phase_q <= PH_LOAD;
					end
				end
				PH_LOAD: begin
					if (q_zero || a_q < q) begin
						phase_q <= op_mul_q ? PH_MUL : PH_DONE;
					end else begin
						phase_q <= PH_RED;
					end
				end
				PH_RED: begin
					if (cnt_q == '0) begin
						phase_q <= op_mul_q ? PH_MUL : PH_DONE;
					end
				end
				PH_MUL: begin
					if (cnt_q == '0) begin
						phase_q <= PH_DONE;
					end
				end
				PH_DONE: phase_q <= PH_IDLE;
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (phase_q)
			PH_IDLE: begin
				if (req.start) begin
					a_q <= a;
					b_q <= b;
				end
			end
			PH_LOAD: begin
				r_q <= '0;
				cnt_q <= '1;
				result_q <= a_q;
			end
			PH_RED: begin
				r_q <= (cnt_q == '0) ? '0 : red_v[WORD_W-1:0];
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					a_q <= red_v[WORD_W-1:0];
					result_q <= red_v[WORD_W-1:0];
				end
			end
			PH_MUL: begin
				r_q <= add_v[WORD_W-1:0];
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					result_q <= add_v[WORD_W-1:0];
				end
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign done = (phase_q == PH_DONE);
	assign result = result_q;
endmodule
`default_nettype wire

### hdl/ntt_modular_transform.sv
// Top level of the modular number-theoretic transform: stream ports, register
// port, run sequencer and output stage. Uses nmt_pkg, nmt_ram, nmt_modmul.
//
// Usage: items enter on the s_axis channel, results leave on m_axis, one
// result per item. tuser of the input carries the mode: write twiddle, write
// coefficient, run, read coefficient. Register writes (cfg_we, cfg_index,
// cfg_data) are taken at any edge with cfg_we high; the user must write them
// only while the block is idle, as the block does not enforce it. Twiddle and
// coefficient writes and reads are accepted back to back while the output
// does not stall; a read's word passes the RAM read register, then the output
// register. A run walks (n/2)*log2(n) butterflies, each made of serial
// reductions and one serial multiply in the shared modular unit, then a bit
// reversal pass over every index, then, in inverse mode, one serial multiply
// per coefficient. The run's result leaves once all of that is done. Reset
// clears the registers to their defaults and empties the pipeline; the stores
// hold no defined contents until written. A stalled receiver holds the output
// register and, once the internal stage behind it fills, stalls input.
`timescale 1ns / 1ps
`default_nettype none
module ntt_modular_transform (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// index [11:0], value [75:12], zeros [79:76]
	input  wire logic [nmt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// mode [1:0]
	input  wire logic [1:0]                      s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// read_value [63:0]
	output logic      [nmt_pkg::WORD_W-1:0]      m_axis_tdata,
	// index_error [0]
	output logic      [0:0]                      m_axis_tuser,
	input  wire logic                            cfg_we,
	input  wire logic [nmt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [nmt_pkg::WORD_W-1:0]      cfg_data
);
	import nmt_pkg::*;

	typedef enum logic [17:0] {
		ST_IDLE     = 18'b000000000000000001,
		ST_BF_RDU   = 18'b000000000000000010,
		ST_BF_RDV   = 18'b000000000000000100,
		ST_BF_CAPV  = 18'b000000000000001000,
		ST_BF_REDU  = 18'b000000000000010000,
		ST_BF_REDV  = 18'b000000000000100000,
		ST_BF_ARITH = 18'b000000000001000000,
		ST_BF_MUL   = 18'b000000000010000000,
		ST_BF_WRLO  = 18'b000000000100000000,
		ST_PM_CHK   = 18'b000000001000000000,
		ST_PM_RDJ   = 18'b000000010000000000,
		ST_PM_CAPJ  = 18'b000000100000000000,
		ST_PM_WRI   = 18'b000001000000000000,
		ST_PM_WRJ   = 18'b000010000000000000,
		ST_SC_RD    = 18'b000100000000000000,
		ST_SC_CAP   = 18'b001000000000000000,
		ST_SC_MUL   = 18'b010000000000000000,
		ST_FIN      = 18'b100000000000000000
	} state_t;

	state_t state_q;

	// registers
	logic [WORD_W-1:0] modulus_q, length_inv_q;
	logic [LOG_W-1:0] log2_len_q;
	logic inverse_q;

	// input fields
	mode_t in_mode;
	logic [IDX_W-1:0] in_index;
	logic [WORD_W-1:0] in_value;
	logic in_xfer, in_err;

	// run counters
	logic [LOG_W-1:0] pass_q, levels, shift_s;
	logic [IDX_W-2:0] bf_j_q;
	logic [IDX_W-1:0] idx_q, n_mask, h_mask, half, jj, lo_addr, hi_addr, w_addr, rev_idx;
	logic [WORD_W-1:0] u_q, v_q, w_q, sum_q, tmp_a_q, tmp_b_q;
	logic [WORD_W:0] sum_t;
	logic [WORD_W-1:0] sum_v, diff_v;
	logic bf_last_j, bf_last_pass, idx_last;

	// memories
	logic coef_we, tw_we;
	logic [IDX_W-1:0] coef_waddr, coef_raddr, rd_hold_q;
	logic [WORD_W-1:0] coef_wdata, coef_rdata, tw_rdata;

	// modular unit
	mul_req_t mreq;
	logic [WORD_W-1:0] m_a, m_b, m_res;
	logic m_done;

	// output stage
	logic s1_v_q, s1_read_q, s1_err_q, out_v_q, out_err_q, out_free, s1_move;
	logic [WORD_W-1:0] out_data_q;

	assign in_mode  = mode_t'(s_axis_tuser);
	assign in_index = s_axis_tdata[IDX_W-1:0];
	assign in_value = s_axis_tdata[IDX_W +: WORD_W];

	assign out_free = !out_v_q || m_axis_tready;
	assign s1_move = s1_v_q && out_free;
	assign s_axis_tready = (state_q == ST_IDLE) && (!s1_v_q || out_free);
	assign in_xfer = s_axis_tvalid && s_axis_tready;

	always_comb begin
		levels = (log2_len_q > LOG_W'(MAX_LOG2_LENGTH)) ? LOG_W'(MAX_LOG2_LENGTH) : log2_len_q;
		n_mask = ~({IDX_W{1'b1}} << levels);
		in_err = (in_index & ~n_mask) != '0;

		// butterfly addressing: span of the current pass is 2^shift_s
		shift_s = levels - pass_q - 1'b1;
		half = {{(IDX_W-1){1'b0}}, 1'b1} << shift_s;
		h_mask = ~({IDX_W{1'b1}} << shift_s);
		jj = {1'b0, bf_j_q};
		lo_addr = (((jj >> shift_s) << 1) << shift_s) | (jj & h_mask);
		hi_addr = lo_addr | half;
		w_addr = (jj & h_mask) << pass_q;
		bf_last_j = (bf_j_q == n_mask[IDX_W-1:1]);
		bf_last_pass = (pass_q == levels - 1'b1);

		rev_idx = mirror_index(idx_q) >> (LOG_W'(IDX_W) - levels);
		idx_last = (idx_q == n_mask);

		sum_t = {1'b0, u_q} + {1'b0, v_q};
		sum_v = (modulus_q != '0 && sum_t >= {1'b0, modulus_q}) ?
			WORD_W'(sum_t - {1'b0, modulus_q}) : sum_t[WORD_W-1:0];
		diff_v = (u_q >= v_q || modulus_q == '0) ? u_q - v_q : u_q - v_q + modulus_q;
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= WORD_W'(2);
			log2_len_q <= LOG_W'(1);
			inverse_q <= 1'b0;
			length_inv_q <= WORD_W'(1);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MODULUS:    modulus_q <= cfg_data;
				REG_LOG2_LEN:   log2_len_q <= cfg_data[LOG_W-1:0];
				REG_INVERSE:    inverse_q <= cfg_data[0];
				REG_LENGTH_INV: length_inv_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// memory port muxing
	always_comb begin
		coef_we = 1'b0;
		coef_waddr = idx_q;
		coef_wdata = tmp_a_q;
		coef_raddr = rd_hold_q;
		tw_we = in_xfer && in_mode == MODE_TWIDDLE;
		unique case (state_q)
			ST_IDLE: begin
				coef_we = in_xfer && in_mode == MODE_COEFF;
				coef_waddr = in_index;
				coef_wdata = in_value;
				if (in_xfer) begin
					coef_raddr = in_index;
				end
			end
			ST_BF_RDU: coef_raddr = lo_addr;
			ST_BF_RDV: coef_raddr = hi_addr;
			ST_BF_MUL: begin
				coef_we = m_done;
				coef_waddr = hi_addr;
				coef_wdata = m_res;
			end
			ST_BF_WRLO: begin
				coef_we = 1'b1;
				coef_waddr = lo_addr;
				coef_wdata = sum_q;
			end
			ST_PM_CHK: coef_raddr = idx_q;
			ST_PM_RDJ: coef_raddr = rev_idx;
			ST_PM_WRI: begin
				coef_we = 1'b1;
				coef_waddr = idx_q;
				coef_wdata = tmp_b_q;
			end
			ST_PM_WRJ: begin
				coef_we = 1'b1;
				coef_waddr = rev_idx;
				coef_wdata = tmp_a_q;
			end
			ST_SC_RD: coef_raddr = idx_q;
			ST_SC_MUL: begin
				coef_we = m_done;
				coef_waddr = idx_q;
				coef_wdata = m_res;
			end
			default: begin
			end
		endcase
	end

	// requests to the modular unit
	always_comb begin
		mreq = '0;
		m_a = u_q;
		m_b = w_q;
		unique case (state_q)
			ST_BF_CAPV: mreq.start = 1'b1;
			// the unit is idle again in the first cycle here; it ignores start while busy
			ST_BF_REDV: begin
				mreq.start = 1'b1;
				m_a = v_q;
			end
			ST_BF_ARITH: begin
				mreq.start = 1'b1;
				mreq.op_mul = 1'b1;
				m_a = diff_v;
			end
			ST_SC_CAP: begin
				mreq.start = 1'b1;
				mreq.op_mul = 1'b1;
				m_a = coef_rdata;
				m_b = length_inv_q;
			end
			default: begin
			end
		endcase
	end

	nmt_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_waddr),
		.wdata (coef_wdata),
		.raddr (coef_raddr),
		.rdata (coef_rdata)
	);

	nmt_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_tw_ram (
		.clk   (clk),
		.we    (tw_we),
		.waddr (in_index),
		.wdata (in_value),
		.raddr (w_addr),
		.rdata (tw_rdata)
	);

	nmt_modmul u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.a      (m_a),
		.b      (m_b),
		.q      (modulus_q),
		.done   (m_done),
		.result (m_res)
	);

	// run sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q <= '0;
			bf_j_q <= '0;
			idx_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && in_mode == MODE_RUN) begin
						pass_q <= '0;
						bf_j_q <= '0;
						idx_q <= '0;
						state_q <= (levels == '0) ? ST_PM_CHK : ST_BF_RDU;
					end
				end
				ST_BF_RDU:   state_q <= ST_BF_RDV;
				ST_BF_RDV:   state_q <= ST_BF_CAPV;
				ST_BF_CAPV:  state_q <= ST_BF_REDU;
				ST_BF_REDU:  if (m_done) state_q <= ST_BF_REDV;
				ST_BF_REDV:  if (m_done) state_q <= ST_BF_ARITH;
				ST_BF_ARITH: state_q <= ST_BF_MUL;
				ST_BF_MUL:   if (m_done) state_q <= ST_BF_WRLO;
				ST_BF_WRLO: begin
					// advance to the next butterfly, or the next pass
					if (!bf_last_j) begin
						bf_j_q <= bf_j_q + 1'b1;
						state_q <= ST_BF_RDU;
					end else if (!bf_last_pass) begin
						bf_j_q <= '0;
						pass_q <= pass_q + 1'b1;
						state_q <= ST_BF_RDU;
					end else begin
						idx_q <= '0;
						state_q <= ST_PM_CHK;
					end
				end
				ST_PM_CHK: begin
					if (idx_q < rev_idx) begin
						state_q <= ST_PM_RDJ;
					end else if (!idx_last) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						idx_q <= '0;
						state_q <= inverse_q ? ST_SC_RD : ST_FIN;
					end
				end
				ST_PM_RDJ:  state_q <= ST_PM_CAPJ;
				ST_PM_CAPJ: state_q <= ST_PM_WRI;
				ST_PM_WRI:  state_q <= ST_PM_WRJ;
				ST_PM_WRJ: begin
					if (!idx_last) begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_PM_CHK;
					end else begin
						idx_q <= '0;
						state_q <= inverse_q ? ST_SC_RD : ST_FIN;
					end
				end
				ST_SC_RD:  state_q <= ST_SC_CAP;
				ST_SC_CAP: state_q <= ST_SC_MUL;
				ST_SC_MUL: begin
					if (m_done) begin
						if (!idx_last) begin
							idx_q <= idx_q + 1'b1;
							state_q <= ST_SC_RD;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN:  state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// run datapath
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			rd_hold_q <= in_index;
		end
		unique case (state_q)
			ST_BF_RDV: begin
				u_q <= coef_rdata;
				w_q <= tw_rdata;
			end
			ST_BF_CAPV: v_q <= coef_rdata;
			ST_BF_REDU: if (m_done) u_q <= m_res;
			ST_BF_REDV: if (m_done) v_q <= m_res;
			ST_BF_ARITH: sum_q <= sum_v;
			ST_PM_RDJ: tmp_a_q <= coef_rdata;
			ST_PM_CAPJ: tmp_b_q <= coef_rdata;
			default: begin
			end
		endcase
	end

	// result stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (in_xfer && in_mode != MODE_RUN) begin
				s1_v_q <= 1'b1;
			end else if (state_q == ST_FIN) begin
				s1_v_q <= 1'b1;
			end else if (s1_move) begin
				s1_v_q <= 1'b0;
			end
			if (s1_move) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && in_mode != MODE_RUN) begin
			s1_read_q <= (in_mode == MODE_READ);
			s1_err_q <= in_err;
		end else if (state_q == ST_FIN) begin
			s1_read_q <= 1'b0;
			s1_err_q <= 1'b0;
		end
		if (s1_move) begin
			out_data_q <= (s1_read_q && !s1_err_q) ? coef_rdata : '0;
			out_err_q <= s1_err_q;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tuser = out_err_q;
endmodule
`default_nettype wire

### hdl/nmt_checker.sv
// Port-level checks for the modular transform top level, attached by bind.
// Uses nmt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nmt_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_axis_tvalid,
	input wire logic                          s_axis_tready,
	input wire logic [1:0]                    s_axis_tuser,
	input wire logic                          m_axis_tvalid,
	input wire logic                          m_axis_tready,
	input wire logic [nmt_pkg::WORD_W-1:0]    m_axis_tdata,
	input wire logic [0:0]                    m_axis_tuser
);
	import nmt_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output transfer dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output data changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata != '0 |-> !m_axis_tuser[0])
		else $error("nonzero read word flagged as index error");

	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == MODE_RUN |=> !s_axis_tready)
		else $error("input taken in the cycle after a run started");
endmodule

bind ntt_modular_transform nmt_checker u_nmt_checker (.*);
`default_nettype wire
